[rtl/sfram_pkg.sv]
package sfram_pkg;

  // field widths fixed by the command format
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned BYTE_W = 8;

  // default array size in bytes
  localparam int unsigned MEM_BYTES_DEF = 262144;

  // opcodes
  localparam logic [BYTE_W-1:0] OP_WRITE = 8'h02;
  localparam logic [BYTE_W-1:0] OP_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] OP_WREN  = 8'h06;

  // address phase lengths
  localparam logic [2:0] ALEN_WREN = 3'd1;
  localparam logic [2:0] ALEN_RW   = 3'd4;

  // chip selects
  localparam logic [1:0] CS_ACCEL = 2'd0;
  localparam logic [1:0] CS_FRAM  = 2'd1;

  // item kinds
  typedef enum logic [1:0] {
    MODE_HDR = 2'd0,
    MODE_WR  = 2'd1,
    MODE_RD  = 2'd2
  } mode_e;

  // open session
  typedef enum logic [1:0] {
    SESS_IDLE  = 2'd0,
    SESS_WRITE = 2'd1,
    SESS_READ  = 2'd2,
    SESS_ACCEL = 2'd3
  } sess_e;

  // address reduction sequencer
  typedef enum logic [1:0] {
    AM_IDLE,
    AM_MUL,
    AM_SUB
  } am_st_e;

  // status of the address reduction unit
  typedef struct packed {
    logic busy;
    logic done;
  } am_stat_t;

  // input item
  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        chip_select;
    logic [BYTE_W-1:0] opcode;
    logic [ADDR_W-1:0] mem_address;
    logic [2:0]        address_length;
    logic [BYTE_W-1:0] write_byte;
  } sfram_in_t;

  // result item
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              from_memory;
  } sfram_out_t;

endpackage

[rtl/sfram_ram.sv]
module sfram_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sfram_amod.sv]
module sfram_amod
  import sfram_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ADDR_W-1:0]            addr_i,
  output am_stat_t                     stat_o,
  output logic [$clog2(MEM_BYTES)-1:0] ptr_o
);

  localparam int unsigned PW    = $clog2(MEM_BYTES);
  localparam bit          IS_P2 = ((64'd1 << PW) == 64'(MEM_BYTES));

  if (IS_P2) begin : g_mask
    // power of two size: the remainder is the low bits
    assign stat_o.busy = 1'b0;
    assign stat_o.done = start_i;
    assign ptr_o       = addr_i[PW-1:0];
  end else begin : g_recip
    // scaled reciprocal, exact quotient for every 24-bit address
    localparam int unsigned     SH      = ADDR_W + PW;
    localparam int unsigned     QW      = ADDR_W + 1 - PW;
    localparam logic [63:0]     RECIP   =
      ((64'd1 << SH) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES);
    localparam logic [ADDR_W:0] RECIP_C = RECIP[ADDR_W:0];

    am_st_e            st_q, st_d;
    logic [ADDR_W-1:0] addr_q;
    logic [QW-1:0]     quo_q, quo_d;
    logic [2*ADDR_W:0] prod;
    logic [ADDR_W-1:0] qm;

    // quotient from the registered address
    assign prod  = {{(ADDR_W+1){1'b0}}, addr_q} * {{ADDR_W{1'b0}}, RECIP_C};
    assign quo_d = QW'(prod >> SH);

    // remainder from the registered quotient
    assign qm    = {{(ADDR_W-QW){1'b0}}, quo_q} * ADDR_W'(MEM_BYTES);
    assign ptr_o = PW'(addr_q - qm);

    // next state
    always_comb begin
      st_d = st_q;
      unique case (st_q)
        AM_IDLE: if (start_i) st_d = AM_MUL;
        AM_MUL:  st_d = AM_SUB;
        AM_SUB:  st_d = AM_IDLE;
        default: st_d = AM_IDLE;
      endcase
    end

    // outputs
    always_comb begin
      stat_o.busy = 1'b0;
      stat_o.done = 1'b0;
      unique case (st_q)
        AM_IDLE: ;
        AM_MUL: begin
          stat_o.busy = 1'b1;
        end
        AM_SUB: begin
          stat_o.busy = 1'b1;
          stat_o.done = 1'b1;
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q <= AM_IDLE;
      end else begin
        st_q <= st_d;
      end
    end

    // datapath
    always_ff @(posedge clk_i) begin
      if (st_q == AM_IDLE && start_i) begin
        addr_q <= addr_i;
      end
      if (st_q == AM_MUL) begin
        quo_q <= quo_d;
      end
    end
  end

endmodule

[rtl/spi_fram_device_model.sv]
// channel   ports                          handshake
// ------    -----------------------------  ----------------------------------
// item in   item_i                         taken when start high, busy low
// result    result_o                       one cycle, marked by strobe_o
//
// one item per cycle while busy is low; a read item's result appears in the
// cycle after it is taken, through the array's registered read port.
// with a power of two array size a header never raises busy; otherwise a header
// that opens a session holds busy while the start address is reduced by a
// reciprocal multiply and a subtract.
// reset clears latch, pointer and session; the array keeps its contents.
// the receiver cannot stall, so results never back up.
module spi_fram_device_model
  import sfram_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  sfram_in_t  item_i,
  output logic       strobe_o,
  output sfram_out_t result_o
);

  localparam int unsigned PW = $clog2(MEM_BYTES);

  logic          acc;
  sess_e         sess_q, sess_d;
  logic          wel_q, wel_d;
  logic [PW-1:0] ptr_q, ptr_d, ptr_inc, am_ptr;
  logic          am_start;
  am_stat_t      am_stat;
  logic          ram_en, ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic          strobe_q, strobe_d;
  logic          fm_q, fm_d;

  assign busy = am_stat.busy;
  assign acc  = start && !busy;

  // pointer advance with wraparound
  assign ptr_inc = (ptr_q == PW'(MEM_BYTES - 1)) ? '0 : ptr_q + PW'(1);

  // header decode and data item handling
  always_comb begin
    sess_d   = sess_q;
    wel_d    = wel_q;
    ptr_d    = ptr_q;
    am_start = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    strobe_d = 1'b0;
    fm_d     = 1'b0;
    if (acc) begin
      case (item_i.mode)
        MODE_HDR: begin
          sess_d = SESS_IDLE;
          if (item_i.chip_select == CS_ACCEL) begin
            sess_d = SESS_ACCEL;
          end else if (item_i.chip_select == CS_FRAM) begin
            if (item_i.opcode == OP_WREN) begin
              wel_d = (item_i.address_length == ALEN_WREN);
            end else begin
              wel_d = 1'b0;
              if (item_i.opcode == OP_WRITE && item_i.address_length == ALEN_RW
                  && wel_q) begin
                sess_d   = SESS_WRITE;
                am_start = 1'b1;
              end else if (item_i.opcode == OP_READ
                           && item_i.address_length == ALEN_RW) begin
                sess_d   = SESS_READ;
                am_start = 1'b1;
              end
            end
          end
        end
        MODE_WR: begin
          if (sess_q == SESS_WRITE) begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            ptr_d  = ptr_inc;
          end
        end
        MODE_RD: begin
          strobe_d = 1'b1;
          if (sess_q == SESS_READ) begin
            ram_en = 1'b1;
            fm_d   = 1'b1;
            ptr_d  = ptr_inc;
          end
        end
        default: ;
      endcase
    end
    // start address lands once reduced
    if (am_stat.done) begin
      ptr_d = am_ptr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q   <= SESS_IDLE;
      wel_q    <= 1'b0;
      ptr_q    <= '0;
      strobe_q <= 1'b0;
      fm_q     <= 1'b0;
    end else begin
      sess_q   <= sess_d;
      wel_q    <= wel_d;
      ptr_q    <= ptr_d;
      strobe_q <= strobe_d;
      fm_q     <= fm_d;
    end
  end

  // start address modulo array size
  sfram_amod #(
    .MEM_BYTES (MEM_BYTES)
  ) u_amod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (am_start),
    .addr_i  (item_i.mem_address),
    .stat_o  (am_stat),
    .ptr_o   (am_ptr)
  );

  // byte array; a write and a read never share a cycle, so no forwarding
  sfram_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ptr_q),
    .wdata_i (item_i.write_byte),
    .rdata_o (ram_rdata)
  );

  // result drive
  assign strobe_o             = strobe_q;
  assign result_o.from_memory = fm_q;
  assign result_o.read_byte   = fm_q ? ram_rdata : '0;

  // a result only follows a taken read item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(acc && item_i.mode == MODE_RD))
    else $error("result without a read item");

  // the array is written only in a write session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (sess_q == SESS_WRITE))
    else $error("array write outside a write session");

  // address reduction only runs for a freshly opened data session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (sess_q == SESS_READ || sess_q == SESS_WRITE))
    else $error("busy without an open data session");

  // a byte from the array is always a marked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.from_memory |-> strobe_o)
    else $error("array byte without strobe");

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfram_pkg::*;

  localparam int unsigned MEM_SIZE     = MEM_BYTES_DEF;
  localparam int unsigned PTR_W        = $clog2(MEM_SIZE);
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE       = 4;
  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam logic [1:0]  CS_NONE      = 2'd2;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  sfram_in_t  item_i;
  logic       strobe_o;
  sfram_out_t result_o;

  // mirror of the device state
  logic [BYTE_W-1:0] fram_copy [MEM_SIZE];
  bit                fram_written [MEM_SIZE];
  logic              wel_copy;
  logic [PTR_W-1:0]  ptr_copy;
  sess_e             sess_copy;

  // read results still to arrive, oldest first
  sfram_out_t        pending_reads [$];
  logic [ADDR_W-1:0] write_starts [$];

  int unsigned items_sent;
  int unsigned bytes_stored;
  int unsigned reads_checked;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idle_on;

  spi_fram_device_model u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("spi_fram_device_model verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // work out what one accepted item does to the device
  function automatic void apply_to_fram(input sfram_in_t it);
    sfram_out_t r;
    r = '0;
    case (it.mode)
      MODE_HDR: begin
        sess_copy = SESS_IDLE;
        if (it.chip_select == CS_ACCEL) begin
          sess_copy = SESS_ACCEL;
        end else if (it.chip_select == CS_FRAM) begin
          if (it.opcode == OP_WREN) begin
            wel_copy = (it.address_length == ALEN_WREN);
          end else begin
            if (it.opcode == OP_WRITE && it.address_length == ALEN_RW && wel_copy) begin
              sess_copy = SESS_WRITE;
              ptr_copy  = PTR_W'(it.mem_address % MEM_SIZE);
            end else if (it.opcode == OP_READ && it.address_length == ALEN_RW) begin
              sess_copy = SESS_READ;
              ptr_copy  = PTR_W'(it.mem_address % MEM_SIZE);
            end
            wel_copy = 1'b0;
          end
        end
      end
      MODE_WR: begin
        if (sess_copy == SESS_WRITE) begin
          fram_copy[ptr_copy]    = it.write_byte;
          fram_written[ptr_copy] = 1'b1;
          ptr_copy = PTR_W'((int'(ptr_copy) + 1) % MEM_SIZE);
          bytes_stored++;
        end
      end
      MODE_RD: begin
        if (sess_copy == SESS_READ) begin
          r.read_byte   = fram_copy[ptr_copy];
          r.from_memory = 1'b1;
          ptr_copy = PTR_W'((int'(ptr_copy) + 1) % MEM_SIZE);
        end
        pending_reads.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  // drive one item, wait for it to be taken, then maybe idle a while
  task automatic send_item(input sfram_in_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    apply_to_fram(it);
    items_sent++;
    if (idle_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // never read an array byte that has not been written
  task automatic send_checked(input sfram_in_t it);
    if (!(it.mode == MODE_RD && sess_copy == SESS_READ && !fram_written[ptr_copy])) begin
      send_item(it);
    end
  endtask

  // random contents in every field, given kind of item
  function automatic sfram_in_t make_item(input logic [1:0] m);
    sfram_in_t it;
    it.mode           = m;
    it.chip_select    = 2'($urandom_range(3));
    it.opcode         = 8'($urandom_range(255));
    it.mem_address    = ADDR_W'($urandom);
    it.address_length = 3'($urandom_range(7));
    it.write_byte     = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_cmd(input logic [1:0] cs, input logic [BYTE_W-1:0] op,
                          input logic [ADDR_W-1:0] addr, input logic [2:0] alen);
    sfram_in_t it;
    it                = make_item(MODE_HDR);
    it.chip_select    = cs;
    it.opcode         = op;
    it.mem_address    = addr;
    it.address_length = alen;
    send_item(it);
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    sfram_in_t it;
    it            = make_item(MODE_WR);
    it.write_byte = b;
    send_item(it);
  endtask

  task automatic get_byte();
    send_checked(make_item(MODE_RD));
  endtask

  // hold the sender until every read result is back
  task automatic wait_results();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
  endtask

  // start addresses, biased to the ends of the array
  function automatic logic [ADDR_W-1:0] pick_write_addr();
    logic [ADDR_W-1:0] a;
    int unsigned       sel;
    sel = $urandom_range(9);
    a   = ADDR_W'($urandom);
    if (sel == 0) begin
      a[PTR_W-1:0] = PTR_W'(MEM_SIZE - 1 - $urandom_range(15));
    end else if (sel == 1) begin
      a[PTR_W-1:0] = PTR_W'($urandom_range(15));
    end
    return a;
  endfunction

  // reads with nothing open: idle, accelerometer, no device, spare mode
  task automatic test_idle_paths();
    get_byte();
    send_cmd(CS_ACCEL, 8'($urandom_range(255)), ADDR_W'($urandom),
             3'($urandom_range(7)));
    get_byte();
    send_item(make_item(MODE_SPARE));
    send_cmd(CS_NONE, OP_READ, '0, ALEN_RW);
    get_byte();
  endtask

  // write enable latch: set, kept, cleared, refused
  task automatic test_latch_rules();
    send_cmd(CS_FRAM, OP_WREN, ADDR_W'($urandom), ALEN_WREN);
    send_cmd(CS_ACCEL, OP_WRITE, '0, ALEN_RW);
    send_cmd(CS_FRAM, OP_WRITE, '1, ALEN_RW);
    put_byte(8'hFF);
    get_byte();
    put_byte(8'h00);
    // latch cleared by the write header
    send_cmd(CS_FRAM, OP_WRITE, '0, ALEN_RW);
    put_byte(8'h5A);
    // wren with the wrong length leaves the latch clear
    send_cmd(CS_FRAM, OP_WREN, '0, 3'd2);
    send_cmd(CS_FRAM, OP_WRITE, '0, ALEN_RW);
    put_byte(8'h66);
    // bad write length refuses and clears
    send_cmd(CS_FRAM, OP_WREN, '0, ALEN_WREN);
    send_cmd(CS_FRAM, OP_WRITE, '0, 3'd3);
    send_cmd(CS_FRAM, OP_WRITE, '0, ALEN_RW);
    put_byte(8'h77);
  endtask

  // read back across the top of the array
  task automatic test_wrap_readback();
    send_cmd(CS_FRAM, OP_READ, '0, 3'd5);
    get_byte();
    send_cmd(CS_FRAM, OP_READ, ADDR_W'(MEM_SIZE - 1), ALEN_RW);
    put_byte(8'h12);
    get_byte();
    get_byte();
  endtask

  // mostly well-formed sessions with random content, some broken, some noise
  task automatic test_random_traffic();
    int unsigned       first;
    int unsigned       kind;
    int unsigned       n;
    logic [ADDR_W-1:0] a;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      // a long quiet stretch with no idling
      idle_on = !((items_sent - first) >= 250 && (items_sent - first) < 450);
      kind = $urandom_range(99);
      if (kind < 30) begin
        // write burst
        a = pick_write_addr();
        if ($urandom_range(9) != 0) begin
          send_cmd(CS_FRAM, OP_WREN, ADDR_W'($urandom), ALEN_WREN);
        end
        send_cmd(CS_FRAM, OP_WRITE, a, ALEN_RW);
        if (sess_copy == SESS_WRITE) begin
          write_starts.push_back(a);
          if (write_starts.size() > 48) void'(write_starts.pop_front());
        end
        n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        repeat (n) put_byte(8'($urandom_range(255)));
      end else if (kind < 60) begin
        // read burst over bytes already written, aliased through the top bits
        if (write_starts.size() != 0) begin
          a = write_starts[$urandom_range(write_starts.size() - 1)];
          a[PTR_W-1:0] = PTR_W'((int'(a[PTR_W-1:0]) + $urandom_range(3)) % MEM_SIZE);
          a[ADDR_W-1:PTR_W] =
            (ADDR_W - PTR_W)'($urandom_range((1 << (ADDR_W - PTR_W)) - 1));
          send_cmd(CS_FRAM, OP_READ, a, ALEN_RW);
          repeat ($urandom_range(1, 12)) get_byte();
        end
      end else if (kind < 70) begin
        // accelerometer or empty chip select
        send_cmd(($urandom_range(1) != 0) ? CS_ACCEL : 2'($urandom_range(2, 3)),
                 8'($urandom_range(255)), ADDR_W'($urandom), 3'($urandom_range(7)));
        repeat ($urandom_range(1, 6)) begin
          send_checked(make_item(($urandom_range(1) != 0) ? MODE_RD : MODE_WR));
        end
      end else if (kind < 85) begin
        // broken write sequences
        send_cmd(CS_FRAM, OP_WREN, ADDR_W'($urandom),
                 ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : ALEN_WREN);
        if ($urandom_range(2) == 0) begin
          send_cmd(2'($urandom_range(3)),
                   ($urandom_range(1) != 0) ? OP_READ : 8'($urandom),
                   pick_write_addr(), 3'($urandom_range(7)));
        end
        a = pick_write_addr();
        send_cmd(CS_FRAM, OP_WRITE, a,
                 ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : ALEN_RW);
        if (sess_copy == SESS_WRITE) write_starts.push_back(a);
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
        if ($urandom_range(1) != 0) get_byte();
      end else begin
        // noise
        repeat ($urandom_range(1, 4)) send_checked(make_item(2'($urandom_range(3))));
      end
    end
    idle_on = 1'b1;
  endtask

  // compare each read result with the oldest one expected
  always @(posedge clk_i) begin
    sfram_out_t want;
    if (rst_ni && strobe_o) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h from_memory %0b",
                                  result_o.read_byte, result_o.from_memory));
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (result_o.read_byte !== want.read_byte) begin
          report_mismatch($sformatf("read_byte %02h, expected %02h",
                                    result_o.read_byte, want.read_byte));
        end
        if (result_o.from_memory !== want.from_memory) begin
          report_mismatch($sformatf("from_memory %0b, expected %0b",
                                    result_o.from_memory, want.from_memory));
        end
      end
    end
  end

  // test sequence
  initial begin
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    item_i    <= '0;
    wel_copy  = 1'b0;
    ptr_copy  = '0;
    sess_copy = SESS_IDLE;
    idle_on   = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_paths();
    wait_results();
    test_latch_rules();
    wait_results();
    test_wrap_readback();
    wait_results();
    test_random_traffic();
    wait_results();
    repeat (SETTLE) @(posedge clk_i);

    if (pending_reads.size() != 0) begin
      report_mismatch($sformatf("%0d read results never arrived", pending_reads.size()));
    end
    $display("covered %0d items: %0d bytes stored, %0d read results checked", items_sent,
             bytes_stored, reads_checked);
    $display("sessions: write, read, accelerometer, no device, latch rules, wraparound");
    if (mismatches == 0) begin
      $display("spi_fram_device_model verification clean");
    end else begin
      $display("spi_fram_device_model verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sfram_pkg.sv
rtl/sfram_ram.sv
rtl/sfram_amod.sv
rtl/spi_fram_device_model.sv
tb/testbench.sv
